/* design/ppmfg_pkg.sv */
// Package for the PPM frame generator: shared types, register codes and defaults.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ppmfg_pkg;

  // Default sizing handed to the top level parameters.
  localparam int MaxChannelsDef = 8;
  localparam int TimeWidthDef   = 16;

  // Number of entries in the queue between the front and back parts.
  localparam int QueueDepth = 2;

  // Input item field widths.
  localparam int IdxW = 3;
  localparam int ValW = 12;

  // Configuration port widths.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PULSE_LENGTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_LENGTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_OUTPUT = 2'd3;

  // Register reset values.
  localparam logic [9:0]  PulseLengthRst  = 10'd300;
  localparam logic [15:0] FrameLengthRst  = 16'd22500;
  localparam logic [3:0]  ChannelCountRst = 4'd8;
  localparam logic [ValW-1:0] ChannelWidthRst = 12'd1500;

  // Classified operation of one queued item.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_DROP
  } op_e;

  // One queued item.
  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] val;
  } entry_t;

  // Configuration register set.
  typedef struct packed {
    logic [9:0]  pulse_length;
    logic [15:0] frame_length;
    logic [3:0]  channel_count;
    logic        invert_output;
  } cfg_t;

endpackage

/* design/ppmfg_front.sv */
// Front part of the PPM frame generator: accepts input items and classifies them.
// Depends on ppmfg_pkg; feeds ppmfg_queue.
`timescale 1ns / 1ps

module ppmfg_front #(
  parameter int MAX_CHANNELS = ppmfg_pkg::MaxChannelsDef
) (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [ppmfg_pkg::IdxW-1:0] channel_index_i,
  input  logic [ppmfg_pkg::ValW-1:0] channel_value_i,
  input  logic                       queue_full_i,
  output logic                       push_o,
  output ppmfg_pkg::entry_t          entry_o
);
  import ppmfg_pkg::*;

  // Hold off the source while the queue has no room.
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Ticks advance time; writes outside the channel table are dropped but
  // still produce a result.
  always_comb begin
    entry_o.idx = channel_index_i;
    entry_o.val = channel_value_i;
    if (!kind_i) begin
      entry_o.op = OP_TICK;
    end else if (32'(channel_index_i) < MAX_CHANNELS) begin
      entry_o.op = OP_WRITE;
    end else begin
      entry_o.op = OP_DROP;
    end
  end

endmodule

/* design/ppmfg_queue.sv */
// Short queue of classified items between the front and back parts.
// Depends on ppmfg_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ppmfg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ppmfg_pkg::entry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output ppmfg_pkg::entry_t entry_o
);
  import ppmfg_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  entry_t            store_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = store_q[rd_ptr_q];

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* design/ppmfg_back.sv */
// Back part of the PPM frame generator: channel table, phase timer and output register.
// Depends on ppmfg_pkg; takes items from ppmfg_queue.
`timescale 1ns / 1ps

module ppmfg_back #(
  parameter int MAX_CHANNELS = ppmfg_pkg::MaxChannelsDef,
  parameter int TIME_WIDTH   = ppmfg_pkg::TimeWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppmfg_pkg::cfg_t   cfg_i,
  input  logic              q_valid_i,
  input  ppmfg_pkg::entry_t q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ppm_level_o,
  output logic              frame_start_o,
  output logic              overrun_o
);
  import ppmfg_pkg::*;

  localparam int SlotW = $clog2(MAX_CHANNELS + 1);
  localparam int TabW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SumW  = 17;
  localparam int DurW  = SumW + 1;
  localparam logic [31:0] TimeMax = (32'd1 << TIME_WIDTH) - 32'd1;

  logic [ValW-1:0]       widths_q [MAX_CHANNELS];
  logic                  in_pulse_q, in_pulse_d;
  logic [SlotW-1:0]      slot_q, slot_d;
  logic [TIME_WIDTH-1:0] time_left_q, time_left_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic                  out_valid_q;
  logic                  level_q, fstart_q, ovr_q;
  logic                  fstart_d, ovr_d;

  logic                  fire;
  logic [SlotW-1:0]      count;
  logic [TIME_WIDTH-1:0] tl;
  logic [DurW-1:0]       dur;
  logic [DurW-1:0]       total;
  logic [ValW-1:0]       width_sel;

  // An item is carried out when the output register is free or drains now.
  assign fire    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = fire;

  // Slots per frame, limited to the table size.
  always_comb begin
    if (32'(cfg_i.channel_count) > MAX_CHANNELS) begin
      count = SlotW'(MAX_CHANNELS);
    end else begin
      count = SlotW'(cfg_i.channel_count);
    end
  end

  assign width_sel = widths_q[slot_q[TabW-1:0]];
  assign total     = DurW'(sum_q) + DurW'(cfg_i.pulse_length);

  // Phase timer, advanced by ticks only: an edge when the timer is empty, then count down.
  always_comb begin
    in_pulse_d  = in_pulse_q;
    slot_d      = slot_q;
    sum_d       = sum_q;
    time_left_d = time_left_q;
    fstart_d    = 1'b0;
    ovr_d       = 1'b0;
    tl          = time_left_q;
    dur         = '0;
    if (q_entry_i.op == OP_TICK) begin
      if (time_left_q == '0) begin
        if (!in_pulse_q) begin
          fstart_d   = (slot_q == '0);
          in_pulse_d = 1'b1;
          dur        = DurW'(cfg_i.pulse_length);
        end else begin
          in_pulse_d = 1'b0;
          if (slot_q >= count) begin
            // Sync gap fills the rest of the frame, clamped on overrun.
            if (total > DurW'(cfg_i.frame_length)) begin
              dur   = '0;
              ovr_d = 1'b1;
            end else begin
              dur = DurW'(cfg_i.frame_length) - total;
            end
            slot_d = '0;
            sum_d  = '0;
          end else begin
            // Channel gap, saturating at zero for a narrow channel.
            if (width_sel > ValW'(cfg_i.pulse_length)) begin
              dur = DurW'(width_sel) - DurW'(cfg_i.pulse_length);
            end else begin
              dur = '0;
            end
            sum_d  = sum_q + SumW'(width_sel);
            slot_d = slot_q + 1'b1;
          end
        end
        if (32'(dur) > TimeMax) begin
          tl = TIME_WIDTH'(TimeMax);
        end else begin
          tl = TIME_WIDTH'(dur);
        end
      end
      if (tl != '0) begin
        time_left_d = tl - 1'b1;
      end else begin
        time_left_d = tl;
      end
    end
  end

  // Channel table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        widths_q[i] <= ChannelWidthRst;
      end
    end else if (fire && (q_entry_i.op == OP_WRITE)) begin
      widths_q[TabW'(q_entry_i.idx)] <= q_entry_i.val;
    end
  end

  // Timer state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pulse_q  <= 1'b0;
      slot_q      <= '0;
      time_left_q <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      level_q     <= 1'b0;
      fstart_q    <= 1'b0;
      ovr_q       <= 1'b0;
    end else begin
      if (fire) begin
        in_pulse_q  <= in_pulse_d;
        slot_q      <= slot_d;
        time_left_q <= time_left_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
        level_q     <= in_pulse_d ? cfg_i.invert_output : !cfg_i.invert_output;
        fstart_q    <= fstart_d;
        ovr_q       <= ovr_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ppm_level_o   = level_q;
  assign frame_start_o = fstart_q;
  assign overrun_o     = ovr_q;

endmodule

/* design/ppm_frame_generator_core.sv */
// PPM frame generator top level: configuration registers, front, queue and back part.
// One result per input item; each item passes through the queue and the output register.
// Throughput is one item per cycle while the output is not stalled.
// A stalled output holds one result in its register while the queue takes up to two more.
// Reset (asynchronous, active low) restores register defaults, fills the channel table
// with 1500 and empties the queue; the block accepts items as soon as reset is released.
`timescale 1ns / 1ps

module ppm_frame_generator_core #(
  parameter int MAX_CHANNELS = ppmfg_pkg::MaxChannelsDef,
  parameter int TIME_WIDTH   = ppmfg_pkg::TimeWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [ppmfg_pkg::IdxW-1:0]     channel_index_i,
  input  logic [ppmfg_pkg::ValW-1:0]     channel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ppm_level_o,
  output logic                           frame_start_o,
  output logic                           overrun_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ppmfg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppmfg_pkg::CfgDataW-1:0] cfg_data_i
);
  import ppmfg_pkg::*;

  cfg_t   cfg_q;
  logic   queue_full, push, q_valid, q_pop;
  entry_t push_entry, q_entry;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_length  <= PulseLengthRst;
      cfg_q.frame_length  <= FrameLengthRst;
      cfg_q.channel_count <= ChannelCountRst;
      cfg_q.invert_output <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PULSE_LENGTH:  cfg_q.pulse_length  <= cfg_data_i[9:0];
        CFG_FRAME_LENGTH:  cfg_q.frame_length  <= cfg_data_i[15:0];
        CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[3:0];
        CFG_INVERT_OUTPUT: cfg_q.invert_output <= cfg_data_i[0];
      endcase
    end
  end

  ppmfg_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .channel_index_i(channel_index_i),
    .channel_value_i(channel_value_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  ppmfg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (queue_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .entry_o(q_entry)
  );

  ppmfg_back #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ppm_level_o  (ppm_level_o),
    .frame_start_o(frame_start_o),
    .overrun_o    (overrun_o)
  );

  // A frame start opens a pulse and an overrun closes one, so they never coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_start_o && overrun_o))
    else $error("frame start and overrun on the same result");

  // A frame start shows the pulse level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_start_o) |-> (ppm_level_o == cfg_q.invert_output))
    else $error("frame start without pulse level");

  // An overrun ends a pulse, so the line is at its idle level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overrun_o) |-> (ppm_level_o != cfg_q.invert_output))
    else $error("overrun without idle level");

  // The input is only held off while the queue holds items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid)
    else $error("input stalled with an empty queue");

endmodule

/* dv/ppm_frame_generator_core_tb.sv */
// Self-checking testbench for the PPM frame generator core.
// Depends on ppmfg_pkg and ppm_frame_generator_core; runs a stimulus table and random phases.
`timescale 1ns / 1ps

module ppm_frame_generator_core_tb;
  import ppmfg_pkg::*;

  localparam int MaxCh       = MaxChannelsDef;
  localparam int TimeW       = TimeWidthDef;
  localparam int TimeMax     = (1 << TimeW) - 1;
  localparam int HoldCycles  = 80;
  localparam int StallLimit  = 3000;
  localparam int MaxReported = 10;
  localparam int PhaseCap    = 400;

  // One line sample as the block reports it.
  typedef struct packed {
    logic level;
    logic frame_start;
    logic overrun;
  } ppm_sample_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_op_e;

  // One row of the directed table. For a register row, addr holds the register index.
  typedef struct packed {
    row_op_e     op;
    logic        kind;
    logic [2:0]  addr;
    logic [15:0] data;
    logic        typed;
    ppm_sample_t want;
  } stim_row_t;

  localparam int NumRows = 20;

  // Sample order in "want" is level, frame_start, overrun.
  localparam stim_row_t DirectedRows [NumRows] = '{
    // Channel writes right after reset: idle line is high, no flags.
    '{ROW_ITEM, 1'b1, 3'd0, 16'd0,    1'b1, 3'b100},
    '{ROW_ITEM, 1'b1, 3'd7, 16'd4095, 1'b1, 3'b100},
    '{ROW_ITEM, 1'b1, 3'd1, 16'd1,    1'b0, 3'b000},
    // Short pulses, two slots, a very short frame, inverted line.
    '{ROW_REG,  1'b0, 3'(CFG_PULSE_LENGTH),  16'd1,    1'b0, 3'b000},
    '{ROW_REG,  1'b0, 3'(CFG_CHANNEL_COUNT), 16'd2,    1'b0, 3'b000},
    '{ROW_REG,  1'b0, 3'(CFG_FRAME_LENGTH),  16'd8,    1'b0, 3'b000},
    '{ROW_REG,  1'b0, 3'(CFG_INVERT_OUTPUT), 16'd1,    1'b0, 3'b000},
    // Inverted idle level is low.
    '{ROW_ITEM, 1'b1, 3'd2, 16'd2730, 1'b1, 3'b000},
    // First tick opens the frame with an inverted (high) pulse.
    '{ROW_ITEM, 1'b0, 3'd5, 16'd4095, 1'b1, 3'b110},
    // Slot 0 is narrower than the pulse and slot 1 equals it: both gaps are empty.
    '{ROW_ITEM, 1'b0, 3'd0, 16'd0,    1'b0, 3'b000},
    '{ROW_ITEM, 1'b0, 3'd7, 16'd1365, 1'b0, 3'b000},
    '{ROW_ITEM, 1'b0, 3'd0, 16'd0,    1'b0, 3'b000},
    '{ROW_ITEM, 1'b0, 3'd0, 16'd0,    1'b0, 3'b000},
    // Closing pulse, then the sync gap is loaded.
    '{ROW_ITEM, 1'b0, 3'd0, 16'd0,    1'b0, 3'b000},
    '{ROW_ITEM, 1'b0, 3'd0, 16'd0,    1'b0, 3'b000},
    // Polarity follows the register at once.
    '{ROW_REG,  1'b0, 3'(CFG_INVERT_OUTPUT), 16'd0, 1'b0, 3'b000},
    '{ROW_ITEM, 1'b1, 3'd5, 16'd2730, 1'b1, 3'b100},
    '{ROW_ITEM, 1'b1, 3'd6, 16'd1365, 1'b0, 3'b000},
    '{ROW_ITEM, 1'b0, 3'd3, 16'd2730, 1'b0, 3'b000},
    '{ROW_ITEM, 1'b0, 3'd4, 16'd1365, 1'b0, 3'b000}
  };

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                kind_i          = 1'b0;
  logic [IdxW-1:0]     channel_index_i = '0;
  logic [ValW-1:0]     channel_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic                ppm_level_o;
  logic                frame_start_o;
  logic                overrun_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  ppm_frame_generator_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .channel_index_i,
    .channel_value_i,
    .out_valid_o,
    .out_stall_i,
    .ppm_level_o,
    .frame_start_o,
    .overrun_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the generator: registers, phase timer and channel table.
  cfg_t                shadow_cfg;
  logic                line_in_pulse;
  logic [3:0]          slot_idx;
  logic [TimeW-1:0]    ticks_left;
  logic [16:0]         frame_sum;
  logic [ValW-1:0]     slot_width [MaxCh];

  ppm_sample_t line_q [$];
  int          mismatches    = 0;
  int          frame_starts  = 0;
  bit          steady_run    = 1'b0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;

  // Advance the shadow generator by one item and return the line sample it yields.
  function automatic ppm_sample_t ppm_line_step(input logic kind, input logic [2:0] idx,
                                                input logic [11:0] val);
    ppm_sample_t s;
    int          slots;
    logic [17:0] total;
    logic [17:0] gap;
    s = '0;
    if (kind) begin
      if (int'(idx) < MaxCh) slot_width[idx] = val;
    end else begin
      if (ticks_left == 0) begin
        if (!line_in_pulse) begin
          s.frame_start = (slot_idx == 0);
          line_in_pulse = 1'b1;
          gap = 18'(shadow_cfg.pulse_length);
        end else begin
          slots = (int'(shadow_cfg.channel_count) > MaxCh) ? MaxCh
                                                            : int'(shadow_cfg.channel_count);
          line_in_pulse = 1'b0;
          if (int'(slot_idx) >= slots) begin
            // Sync gap fills the frame; it clamps to zero on overrun.
            total = 18'(frame_sum) + 18'(shadow_cfg.pulse_length);
            if (total > 18'(shadow_cfg.frame_length)) begin
              gap = '0;
              s.overrun = 1'b1;
            end else begin
              gap = 18'(shadow_cfg.frame_length) - total;
            end
            slot_idx  = '0;
            frame_sum = '0;
          end else begin
            gap = (slot_width[slot_idx] > 12'(shadow_cfg.pulse_length))
                  ? 18'(slot_width[slot_idx] - 12'(shadow_cfg.pulse_length)) : '0;
            frame_sum = frame_sum + 17'(slot_width[slot_idx]);
            slot_idx  = slot_idx + 4'd1;
          end
        end
        ticks_left = (int'(gap) > TimeMax) ? TimeW'(TimeMax) : TimeW'(gap);
      end
      if (ticks_left != 0) ticks_left = ticks_left - 1'b1;
    end
    s.level = line_in_pulse ? shadow_cfg.invert_output : ~shadow_cfg.invert_output;
    return s;
  endfunction

  // Channel widths stay short so that frames wrap within a phase.
  function automatic logic [11:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 12'd0;
    if (r < 10) return 12'($urandom_range(40, 120));
    return 12'($urandom_range(0, 30));
  endfunction

  // Offer one item, wait for its transfer and record the sample it should produce.
  task automatic offer_item(input logic kind, input logic [2:0] idx, input logic [11:0] val,
                            input logic typed, input ppm_sample_t want);
    ppm_sample_t predicted;
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 24) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i      = 1'b1;
    kind_i          = kind;
    channel_index_i = idx;
    channel_value_i = val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = ppm_line_step(kind, idx, val);
    if (predicted.frame_start) frame_starts++;
    line_q.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected sample has been seen.
  task automatic settle();
    in_valid_i = 1'b0;
    while (line_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PULSE_LENGTH:  shadow_cfg.pulse_length  = data[9:0];
      CFG_FRAME_LENGTH:  shadow_cfg.frame_length  = data;
      CFG_CHANNEL_COUNT: shadow_cfg.channel_count = data[3:0];
      CFG_INVERT_OUTPUT: shadow_cfg.invert_output = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input logic [9:0] pulse, input logic [15:0] frame,
                            input logic [3:0] count, input logic invert);
    settle();
    write_reg(CFG_PULSE_LENGTH, 16'(pulse));
    write_reg(CFG_FRAME_LENGTH, frame);
    write_reg(CFG_CHANNEL_COUNT, 16'(count));
    write_reg(CFG_INVERT_OUTPUT, 16'(invert));
  endtask

  task automatic fill_widths();
    for (int ch = 0; ch < MaxCh; ch++) offer_item(1'b1, 3'(ch), pick_width(), 1'b0, '0);
  endtask

  // Mostly ticks with random unused fields, some channel writes mid-frame.
  task automatic run_ticks(input int min_items, input bit need_wrap, input int pause_at);
    int n;
    n = 0;
    frame_starts = 0;
    while (n < min_items || (need_wrap && frame_starts < 2 && n < PhaseCap)) begin
      if (n == pause_at) settle();
      if ($urandom_range(0, 99) < 15) begin
        offer_item(1'b1, 3'($urandom_range(0, 7)), pick_width(), 1'b0, '0);
      end else begin
        offer_item(1'b0, 3'($urandom_range(0, 7)), 12'($urandom), 1'b0, '0);
      end
      n++;
    end
  endtask

  // Receiver: random stalls, an occasional long hold-off, and quiet stretches.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done  <= holds_done + 1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady_run && ($urandom_range(0, 99) < 24);
    end
  end

  // Compare each result transfer with the oldest expected sample.
  always @(posedge clk_i) begin
    ppm_sample_t got;
    ppm_sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{ppm_level_o, frame_start_o, overrun_o};
      if (line_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result: level %b frame_start %b overrun %b",
                   got.level, got.frame_start, got.overrun);
      end else begin
        want = line_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("mismatch: level %b/%b frame_start %b/%b overrun %b/%b (exp/act)",
                     want.level, got.level, want.frame_start, got.frame_start,
                     want.overrun, got.overrun);
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("ppm_frame_generator_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    shadow_cfg    = '{PulseLengthRst, FrameLengthRst, ChannelCountRst, 1'b0};
    line_in_pulse = 1'b0;
    slot_idx      = '0;
    ticks_left    = '0;
    frame_sum     = '0;
    for (int ch = 0; ch < MaxCh; ch++) slot_width[ch] = ChannelWidthRst;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    for (int i = 0; i < NumRows; i++) begin
      row = DirectedRows[i];
      if (row.op == ROW_REG) begin
        settle();
        write_reg(row.addr[CfgIdxW-1:0], row.data);
      end else begin
        offer_item(row.kind, row.addr, row.data[11:0], row.typed, row.want);
      end
    end

    // Pulse longer than the frame and no channel slots: every sync gap overruns.
    set_config(10'd40, 16'd30, 4'd0, 1'b0);
    run_ticks(120, 1'b1, -1);

    // Channel count above the table size, with no idling on either side.
    steady_run = 1'b1;
    set_config(10'($urandom_range(1, 20)), 16'd100, 4'd15, 1'b1);
    fill_widths();
    run_ticks(250, 1'b1, -1);
    steady_run = 1'b0;

    // One wide slot that alone overruns the frame.
    set_config(10'($urandom_range(1, 10)), 16'd100, 4'd1, 1'b0);
    fill_widths();
    offer_item(1'b1, 3'd0, 12'd150, 1'b0, '0);
    run_ticks(200, 1'b1, -1);

    // Random settings; the first holds the receiver off, the second drains mid-phase.
    for (int p = 0; p < 3; p++) begin
      set_config(($urandom_range(0, 3) == 0) ? 10'($urandom_range(21, 60))
                                              : 10'($urandom_range(1, 20)),
                 16'($urandom_range(40, 200)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
      fill_widths();
      if (p == 0) hold_requests++;
      run_ticks(150, 1'b1, (p == 1) ? 75 : -1);
    end

    // Longest frame comes last, since its sync gap outlasts the run.
    set_config(10'd1, 16'd65535, 4'd2, 1'b1);
    fill_widths();
    run_ticks(100, 1'b0, -1);

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && line_q.size() == 0) begin
      $display("ppm_frame_generator_core_tb: PASS");
    end else begin
      $display("ppm_frame_generator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
